/* design/ucs_pkg.sv */
// Types, constants and character-class functions for the URI component splitter.
`timescale 1ns / 1ps

package ucs_pkg;

	localparam int MAX_LEN = 4096;
	localparam int IDX_W   = $clog2(MAX_LEN + 1);
	localparam int POS_W   = 12;
	localparam int POS_MAX = (1 << POS_W) - 1;
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_QUEST   = 8'h3F;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_COLON   = 8'h3A;

	typedef enum logic [3:0] {
		PH_SCHEME_FIRST,
		PH_SCHEME_REST,
		PH_AFTER_COLON,
		PH_HELD_SLASH,
		PH_AUTHORITY,
		PH_PATH,
		PH_QUERY,
		PH_FRAGMENT,
		PH_SKIP
	} phase_t;

	typedef enum logic [2:0] {
		C_SCHEME,
		C_DELIM,
		C_AUTHORITY,
		C_PATH,
		C_QUERY,
		C_FRAGMENT
	} comp_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_BAD_SCH,
		ST_BAD_QRY,
		ST_BAD_FRAG,
		ST_TOO_LONG
	} status_t;

	typedef struct packed {
		phase_t           phase;
		logic [1:0]       hex_left;
		logic [IDX_W-1:0] byte_index;
	} state_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic [7:0]       char_out;
		comp_t            component;
		logic             done_res;
		status_t          status;
	} result_t;

	localparam state_t STATE_RESET = '{phase: PH_SCHEME_FIRST, hex_left: 2'd0, byte_index: '0};

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic is_pchar_plain(input logic [7:0] c);
		logic r;
		case (c)
			8'h3A, 8'h40, 8'h2D, 8'h2E, 8'h5F, 8'h7E, 8'h21, 8'h24, 8'h26,
			8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D: r = 1'b1;
			default: r = is_alpha(c) || is_digit(c);
		endcase
		return r;
	endfunction

	function automatic comp_t phase_component(input phase_t ph);
		comp_t r;
		case (ph)
			PH_SCHEME_FIRST, PH_SCHEME_REST: r = C_SCHEME;
			PH_AUTHORITY:                    r = C_AUTHORITY;
			PH_QUERY:                        r = C_QUERY;
			PH_FRAGMENT:                     r = C_FRAGMENT;
			default:                         r = C_PATH;
		endcase
		return r;
	endfunction

	function automatic result_t mk_res(input logic [IDX_W-1:0] pos, input logic [7:0] ch,
			input comp_t comp, input logic done, input status_t st);
		result_t r;
		r.position  = (pos > IDX_W'(POS_MAX)) ? POS_W'(POS_MAX) : pos[POS_W-1:0];
		r.char_out  = ch;
		r.component = comp;
		r.done_res  = done;
		r.status    = st;
		return r;
	endfunction

endpackage

/* design/ucs_step.sv */
// Per-byte classification: next state and up to two tagged results.
`timescale 1ns / 1ps

module ucs_step (
	input  ucs_pkg::state_t  state,
	input  logic [7:0]       byte_value,
	input  logic             is_last,
	output ucs_pkg::state_t  state_next,
	output ucs_pkg::result_t res [2],
	output logic [1:0]       res_count
);

	always_comb begin
		ucs_pkg::phase_t          ph;
		ucs_pkg::phase_t          nph;
		logic [ucs_pkg::IDX_W-1:0] idx;
		logic [1:0]               nhex;
		logic                     cont;
		logic                     frag;
		ucs_pkg::comp_t           comp;
		ucs_pkg::status_t         st;
		ucs_pkg::status_t         bad;

		ph         = state.phase;
		idx        = state.byte_index;
		nph        = ph;
		nhex       = state.hex_left;
		cont       = 1'b1;
		frag       = 1'b0;
		comp       = ucs_pkg::C_PATH;
		st         = ucs_pkg::ST_OK;
		bad        = ucs_pkg::ST_BAD_QRY;
		state_next = state;
		res[0]     = '0;
		res[1]     = '0;
		res_count  = 2'd0;

		if (ph == ucs_pkg::PH_SKIP) begin
			cont = 1'b0;
			if (is_last) begin
				state_next = ucs_pkg::STATE_RESET;
			end
		end

		if (cont && ph == ucs_pkg::PH_HELD_SLASH) begin
			if (byte_value == ucs_pkg::CH_SLASH &&
					idx < ucs_pkg::IDX_W'(ucs_pkg::MAX_LEN)) begin
				res[0] = ucs_pkg::mk_res(idx - 1'b1, ucs_pkg::CH_SLASH, ucs_pkg::C_DELIM,
					1'b0, ucs_pkg::ST_OK);
				res[1] = ucs_pkg::mk_res(idx, ucs_pkg::CH_SLASH, ucs_pkg::C_DELIM,
					is_last, ucs_pkg::ST_OK);
				res_count = 2'd2;
				cont = 1'b0;
				if (is_last) begin
					state_next = ucs_pkg::STATE_RESET;
				end else begin
					state_next.phase      = ucs_pkg::PH_AUTHORITY;
					state_next.byte_index = idx + 1'b1;
				end
			end else begin
				res[0] = ucs_pkg::mk_res(idx - 1'b1, ucs_pkg::CH_SLASH, ucs_pkg::C_PATH,
					1'b0, ucs_pkg::ST_OK);
				res_count = 2'd1;
				ph = ucs_pkg::PH_PATH;
			end
		end

		if (cont && idx >= ucs_pkg::IDX_W'(ucs_pkg::MAX_LEN)) begin
			res[res_count[0]] = ucs_pkg::mk_res(idx, byte_value, ucs_pkg::phase_component(ph),
				1'b1, ucs_pkg::ST_TOO_LONG);
			res_count = res_count + 2'd1;
			cont = 1'b0;
			if (is_last) begin
				state_next = ucs_pkg::STATE_RESET;
			end else begin
				state_next.phase = ucs_pkg::PH_SKIP;
			end
		end

		if (cont && ph == ucs_pkg::PH_AFTER_COLON) begin
			if (byte_value == ucs_pkg::CH_SLASH && !is_last) begin
				cont = 1'b0;
				state_next.phase      = ucs_pkg::PH_HELD_SLASH;
				state_next.byte_index = idx + 1'b1;
			end else begin
				ph = ucs_pkg::PH_PATH;
			end
		end

		if (cont) begin
			nph = ph;
			case (ph)
				ucs_pkg::PH_SCHEME_FIRST, ucs_pkg::PH_SCHEME_REST: begin
					comp = ucs_pkg::C_SCHEME;
					if (byte_value == ucs_pkg::CH_COLON) begin
						comp = ucs_pkg::C_DELIM;
						nph  = ucs_pkg::PH_AFTER_COLON;
					end else if (ucs_pkg::is_alpha(byte_value) ||
							(ph == ucs_pkg::PH_SCHEME_REST &&
							(ucs_pkg::is_digit(byte_value) || byte_value == 8'h2B ||
							byte_value == 8'h2D || byte_value == 8'h2E))) begin
						nph = ucs_pkg::PH_SCHEME_REST;
						if (is_last) begin
							st = ucs_pkg::ST_BAD_SCH;
						end
					end else begin
						st = ucs_pkg::ST_BAD_SCH;
					end
				end
				ucs_pkg::PH_AUTHORITY: begin
					if (byte_value == ucs_pkg::CH_SLASH) begin
						comp = ucs_pkg::C_PATH;
						nph  = ucs_pkg::PH_PATH;
					end else if (byte_value == ucs_pkg::CH_QUEST) begin
						comp = ucs_pkg::C_DELIM;
						nph  = ucs_pkg::PH_QUERY;
					end else if (byte_value == ucs_pkg::CH_HASH) begin
						comp = ucs_pkg::C_DELIM;
						nph  = ucs_pkg::PH_FRAGMENT;
					end else begin
						comp = ucs_pkg::C_AUTHORITY;
					end
				end
				ucs_pkg::PH_QUERY, ucs_pkg::PH_FRAGMENT: begin
					frag = (ph == ucs_pkg::PH_FRAGMENT);
					bad  = frag ? ucs_pkg::ST_BAD_FRAG : ucs_pkg::ST_BAD_QRY;
					comp = frag ? ucs_pkg::C_FRAGMENT : ucs_pkg::C_QUERY;
					if (state.hex_left != 2'd0) begin
						if (ucs_pkg::is_hex(byte_value)) begin
							nhex = state.hex_left - 2'd1;
						end else begin
							st = bad;
						end
					end else if (byte_value == ucs_pkg::CH_PERCENT) begin
						nhex = 2'd2;
					end else if (ucs_pkg::is_pchar_plain(byte_value) ||
							byte_value == ucs_pkg::CH_QUEST ||
							byte_value == ucs_pkg::CH_SLASH) begin
						nhex = 2'd0;
					end else if (byte_value == ucs_pkg::CH_HASH && !frag) begin
						comp = ucs_pkg::C_DELIM;
						nph  = ucs_pkg::PH_FRAGMENT;
					end else begin
						st = bad;
					end
					if (st == ucs_pkg::ST_OK && is_last && nhex != 2'd0) begin
						st = bad;
					end
				end
				default: begin
					if (byte_value == ucs_pkg::CH_QUEST) begin
						comp = ucs_pkg::C_DELIM;
						nph  = ucs_pkg::PH_QUERY;
					end else if (byte_value == ucs_pkg::CH_HASH) begin
						comp = ucs_pkg::C_DELIM;
						nph  = ucs_pkg::PH_FRAGMENT;
					end else begin
						comp = ucs_pkg::C_PATH;
					end
				end
			endcase

			res[res_count[0]] = ucs_pkg::mk_res(idx, byte_value, comp,
				is_last || st != ucs_pkg::ST_OK, st);
			res_count = res_count + 2'd1;

			if (is_last) begin
				state_next = ucs_pkg::STATE_RESET;
			end else if (st != ucs_pkg::ST_OK) begin
				state_next.phase    = ucs_pkg::PH_SKIP;
				state_next.hex_left = 2'd0;
			end else begin
				state_next.phase      = nph;
				state_next.hex_left   = nhex;
				state_next.byte_index = idx + 1'b1;
			end
		end
	end

endmodule

/* design/ucs_outq.sv */
// Four-entry result queue taking up to two results per cycle.
`timescale 1ns / 1ps

module ucs_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_count,
	input  ucs_pkg::result_t push_data [2],
	input  logic             pop,
	output logic             head_valid,
	output ucs_pkg::result_t head_data,
	output logic             room_for_two
);

	ucs_pkg::result_t                    entry_q [ucs_pkg::OQ_DEPTH];
	logic [ucs_pkg::OQ_PTR_W-1:0]        wr_ptr_q;
	logic [ucs_pkg::OQ_PTR_W-1:0]        rd_ptr_q;
	logic [ucs_pkg::OQ_CNT_W-1:0]        count_q;
	logic                                do_pop;

	assign head_valid   = (count_q != '0);
	assign head_data    = entry_q[rd_ptr_q];
	assign room_for_two = (count_q <= ucs_pkg::OQ_CNT_W'(ucs_pkg::OQ_DEPTH - 2));
	assign do_pop       = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			entry_q[wr_ptr_q] <= push_data[0];
		end
		if (push_count == 2'd2) begin
			entry_q[wr_ptr_q + 1'b1] <= push_data[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + ucs_pkg::OQ_PTR_W'(push_count);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + ucs_pkg::OQ_CNT_W'(push_count)
				- ucs_pkg::OQ_CNT_W'(do_pop);
		end
	end

endmodule

/* design/uri_component_splitter_top.sv */
// Top level of the URI component splitter: input register, byte classifier, result queue.
`timescale 1ns / 1ps

// Takes one URI byte per request and returns each byte tagged as scheme, delimiter,
// authority, path, query or fragment, with its position and a status. A byte is taken
// every cycle while the queue has room; it is classified in the cycle after acceptance and
// its results enter a four-entry queue at an edge where two entries are free. Most bytes
// give one result; a slash following the colon gives none until the next byte, which then
// yields two, and after an error bytes up to the end of the URI give none. The output port
// carries one result per cycle while m_axis_tready is high; the two results of a held slash
// always follow a byte that gave none, so with the output ready bytes are taken every
// cycle. The queue accepts a byte only with two free entries, so output stalls hold the
// input. Positions saturate at 4095; a byte beyond the length limit ends the URI with a
// too-long status.
module uri_component_splitter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
	input  logic        s_axis_tlast,   // is_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [11:0] position, [19:12] char_out, [22:20] status
	output logic [2:0]  m_axis_tuser,   // [2:0] component
	output logic        m_axis_tlast    // done_res
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	ucs_pkg::state_t   state_q;
	ucs_pkg::state_t   state_next;
	ucs_pkg::result_t  step_res [2];
	logic [1:0]        step_count;
	logic              room_for_two;
	logic              advance;
	ucs_pkg::result_t  head;

	assign advance       = valid_s1 && room_for_two;
	assign s_axis_tready = !valid_s1 || room_for_two;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ucs_pkg::STATE_RESET;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	ucs_step u_step (
		.state      (state_q),
		.byte_value (byte_s1),
		.is_last    (last_s1),
		.state_next (state_next),
		.res        (step_res),
		.res_count  (step_count)
	);

	ucs_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_count   (advance ? step_count : 2'd0),
		.push_data    (step_res),
		.pop          (m_axis_tready),
		.head_valid   (m_axis_tvalid),
		.head_data    (head),
		.room_for_two (room_for_two)
	);

	assign m_axis_tdata = {1'b0, head.status, head.char_out, head.position};
	assign m_axis_tuser = head.component;
	assign m_axis_tlast = head.done_res;

endmodule
